[hw/rtl/ohp_pkg.sv]
// ----------------------------------------------------------------------------
// ohp_pkg
// Shared types and constants for the observation history packer.
// ----------------------------------------------------------------------------
`default_nettype none

package ohp_pkg;

  // Default sizing of the history store
  localparam int DefMaxSteps      = 8;
  localparam int DefMaxFrameWidth = 64;
  localparam int DefMaxTerms      = 6;

  // Term width registers present in the register map
  localparam int NumTermRegs = 6;

  // Register map
  localparam logic [2:0] REG_STEPS = 3'd0;
  localparam logic [2:0] REG_TERMS = 3'd1;
  localparam logic [2:0] REG_TW_A  = 3'd2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BUSY   = 3'd2,
    ST_RANGE  = 3'd3,
    ST_LENGTH = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_SEARCH,
    S_DIVIDE,
    S_ADDR,
    S_MEMRD,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/ohp_if.sv]
// ----------------------------------------------------------------------------
// ohp_if
// Valid/ready channels of the observation history packer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ohp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] element_value;
  logic        frame_end;
  logic        layout;
  logic [8:0]  packed_index;

  modport source (output valid, operation, element_value, frame_end, layout,
                  packed_index, input ready);
  modport sink   (input valid, operation, element_value, frame_end, layout,
                  packed_index, output ready);
endinterface

interface ohp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [2:0]  status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

[hw/rtl/observation_history_packer.sv]
// ----------------------------------------------------------------------------
// observation_history_packer
// Ring of the last N observation frames, read back as a packed vector.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per item: append an element (frame_end closes the
//   frame), clear the history, or read one element of the packed vector in
//   term-major or time-major layout. out_o returns one word per item with
//   the element (reads) and a status code.
//   Configuration writes (cfg_we_i) clear the history and the staged frame.
// Sequencing (accept to result valid):
//   append/clear/other: from idle to the done state, then the output register.
//   frame close, commit: the copy loop moves the staged frame into the new
//   slot, one staging-to-ring copy word per cycle, or into all S slots for
//   the first frame after a clear.
//   read: term-major first searches the terms; both layouts then run the
//   index divider (age < S, set by its subtract loop), address and memory read.
// Throughput: one item at a time; the next item is taken once the result
//   sits in the output register.
// Reset: history empty, no staged elements, registers at their defaults.
// Stall: a held result keeps the block in its done state; it does not lose
//   or repeat a word.
// ----------------------------------------------------------------------------
`default_nettype none

module observation_history_packer
  import ohp_pkg::*;
#(
  parameter int MAX_STEPS       = DefMaxSteps,
  parameter int MAX_FRAME_WIDTH = DefMaxFrameWidth,
  parameter int MAX_TERMS       = DefMaxTerms
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [6:0] cfg_data_i,
  ohp_in_if.sink          in_i,
  ohp_out_if.source       out_o
);

  localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int EW = (MAX_FRAME_WIDTH > 1) ? $clog2(MAX_FRAME_WIDTH) : 1;
  localparam int CW = $clog2(MAX_FRAME_WIDTH + 2);
  localparam int AW = ((MAX_STEPS * MAX_FRAME_WIDTH) > 1) ?
                      $clog2(MAX_STEPS * MAX_FRAME_WIDTH) : 1;
  localparam int Depth = MAX_STEPS * MAX_FRAME_WIDTH;

  // Configuration registers
  logic [3:0] steps_q;
  logic [2:0] terms_q;
  logic [6:0] tw_q [NumTermRegs];

  // Control state
  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [SW-1:0]   newest_q, newest_d;
  logic            filled_q, filled_d;
  logic [SW-1:0]   cp_slot_q, cp_slot_d;
  logic [EW-1:0]   cp_j_q, cp_j_d;
  logic            cp_all_q, cp_all_d;
  logic            wr_vld_q, wr_vld_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;
  logic [9:0]      rem_q, rem_d;
  logic [9:0]      div_q, div_d;
  logic [9:0]      ebase_q, ebase_d;
  logic [3:0]      age_q, age_d;
  logic [2:0]      term_q, term_d;
  logic [AW-1:0]   raddr_q, raddr_d;
  status_e         res_stat_q, res_stat_d;
  logic            res_mem_q, res_mem_d;
  logic            out_vld_q, out_vld_d;
  logic [31:0]     out_val_q, out_val_d;
  status_e         out_stat_q, out_stat_d;

  // Memories
  logic [31:0] stg_mem [MAX_FRAME_WIDTH];
  logic [31:0] frame_mem [Depth];
  logic [31:0] stg_rdata_q;
  logic [31:0] frame_rdata_q;

  // Effective configuration
  logic [3:0]  eff_s;
  logic [2:0]  eff_t;
  logic [9:0]  base_w;
  logic [13:0] span;
  logic        w_ok;

  always_comb begin
    if (steps_q == 4'd0) begin
      eff_s = 4'd1;
    end else if (int'(steps_q) > MAX_STEPS) begin
      eff_s = 4'(MAX_STEPS);
    end else begin
      eff_s = steps_q;
    end
    if (terms_q == 3'd0) begin
      eff_t = 3'd1;
    end else if (int'(terms_q) > MAX_TERMS) begin
      eff_t = 3'(MAX_TERMS);
    end else begin
      eff_t = terms_q;
    end
  end

  // Base width: sum of the active term widths
  always_comb begin
    base_w = '0;
    for (int i = 0; i < NumTermRegs; i++) begin
      if (i < int'(eff_t)) begin
        base_w = base_w + 10'(tw_q[i]);
      end
    end
  end

  assign span = 14'(base_w * eff_s);
  assign w_ok = (base_w != 10'd0) && (int'(base_w) <= MAX_FRAME_WIDTH);

  // Handshake
  logic acc;
  logic out_free;
  assign in_i.ready  = (state_q == S_IDLE);
  assign acc         = in_i.valid && in_i.ready;
  assign out_free    = !out_vld_q || out_o.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.read_value = out_val_q;
  assign out_o.status     = out_stat_q;

  // Append decode
  logic [CW-1:0] cnt_inc;
  logic          stg_we;
  logic          commit_ok;
  assign cnt_inc   = (int'(cnt_q) <= MAX_FRAME_WIDTH) ? cnt_q + CW'(1) : cnt_q;
  assign stg_we    = acc && (op_e'(in_i.operation) == OP_APPEND) &&
                     (int'(cnt_q) < MAX_FRAME_WIDTH);
  assign commit_ok = w_ok && (int'(cnt_inc) == int'(base_w));

  // Search and slot helpers
  logic [6:0]  cur_tw;
  logic [10:0] cur_len;
  logic        hit;
  int          slot_sum;
  int          next_slot;
  logic        copy_last;
  assign cur_tw  = tw_q[term_q];
  assign cur_len = 11'(cur_tw * eff_s);
  assign hit     = (cur_tw != 7'd0) && ({1'b0, rem_q} < cur_len);
  assign copy_last = (int'(cp_j_q) == int'(base_w) - 1);

  always_comb begin
    slot_sum = int'(newest_q) + 1 + int'(age_q);
    if (slot_sum >= int'(eff_s)) begin
      slot_sum = slot_sum - int'(eff_s);
    end
    next_slot = int'(newest_q) + 1;
    if (next_slot >= int'(eff_s)) begin
      next_slot = 0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = S_DONE;
          case (op_e'(in_i.operation))
            OP_APPEND: begin
              if (in_i.frame_end && commit_ok) begin
                state_d = S_COPY;
              end
            end
            OP_READ: begin
              if (filled_q && cnt_q == '0 && w_ok &&
                  {5'd0, in_i.packed_index} < span) begin
                state_d = in_i.layout ? S_DIVIDE : S_SEARCH;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_COPY: begin
        if (copy_last && !(cp_all_q && int'(cp_slot_q) != int'(eff_s) - 1)) begin
          state_d = S_DONE;
        end
      end
      S_SEARCH: if (hit) state_d = S_DIVIDE;
      S_DIVIDE: if (rem_q < div_q) state_d = S_ADDR;
      S_ADDR:   state_d = S_MEMRD;
      S_MEMRD:  state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_d      = cnt_q;
    newest_d   = newest_q;
    filled_d   = filled_q;
    cp_slot_d  = cp_slot_q;
    cp_j_d     = cp_j_q;
    cp_all_d   = cp_all_q;
    wr_vld_d   = 1'b0;
    wr_addr_d  = wr_addr_q;
    rem_d      = rem_q;
    div_d      = div_q;
    ebase_d    = ebase_q;
    age_d      = age_q;
    term_d     = term_q;
    raddr_d    = raddr_q;
    res_stat_d = res_stat_q;
    res_mem_d  = res_mem_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_val_d  = out_val_q;
    out_stat_d = out_stat_q;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          res_stat_d = ST_OK;
          res_mem_d  = 1'b0;
          case (op_e'(in_i.operation))
            OP_APPEND: begin
              cnt_d = cnt_inc;
              if (in_i.frame_end) begin
                cnt_d  = '0;
                cp_j_d = '0;
                if (commit_ok) begin
                  if (!filled_q) begin
                    cp_slot_d = '0;
                    cp_all_d  = 1'b1;
                    newest_d  = SW'(int'(eff_s) - 1);
                    filled_d  = 1'b1;
                  end else begin
                    cp_slot_d = SW'(next_slot);
                    cp_all_d  = 1'b0;
                    newest_d  = SW'(next_slot);
                  end
                end else begin
                  res_stat_d = ST_LENGTH;
                end
              end
            end
            OP_CLEAR: begin
              cnt_d    = '0;
              newest_d = '0;
              filled_d = 1'b0;
            end
            OP_READ: begin
              rem_d   = {1'b0, in_i.packed_index};
              div_d   = base_w;
              ebase_d = '0;
              age_d   = '0;
              term_d  = '0;
              if (!filled_q) begin
                res_stat_d = ST_EMPTY;
              end else if (cnt_q != '0) begin
                res_stat_d = ST_BUSY;
              end else if (!w_ok || {5'd0, in_i.packed_index} >= span) begin
                res_stat_d = ST_RANGE;
              end
            end
            default: res_stat_d = ST_OK;
          endcase
        end
      end
      S_COPY: begin
        // staging word j is registered with its ring address, then written to the ring
        wr_vld_d  = 1'b1;
        wr_addr_d = AW'(int'(cp_slot_q) * MAX_FRAME_WIDTH + int'(cp_j_q));
        if (copy_last) begin
          cp_j_d    = '0;
          cp_slot_d = cp_slot_q + SW'(1);
        end else begin
          cp_j_d = cp_j_q + EW'(1);
        end
      end
      S_SEARCH: begin
        if (hit) begin
          div_d = 10'(cur_tw);
        end else begin
          rem_d   = 10'(11'(rem_q) - cur_len);
          ebase_d = ebase_q + 10'(cur_tw);
          term_d  = term_q + 3'd1;
        end
      end
      S_DIVIDE: begin
        if (rem_q >= div_q) begin
          rem_d = rem_q - div_q;
          age_d = age_q + 4'd1;
        end
      end
      S_ADDR: begin
        raddr_d = AW'(slot_sum * MAX_FRAME_WIDTH + int'(ebase_q + rem_q));
      end
      S_MEMRD: res_mem_d = 1'b1;
      S_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_val_d  = res_mem_q ? frame_rdata_q : 32'd0;
          out_stat_d = res_stat_q;
        end
      end
      default: res_mem_d = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q    <= 4'd4;
      terms_q    <= 3'd1;
      for (int i = 0; i < NumTermRegs; i++) begin
        tw_q[i] <= (i == 0) ? 7'd64 : 7'd0;
      end
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      newest_q   <= '0;
      filled_q   <= 1'b0;
      wr_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      res_mem_q  <= 1'b0;
      res_stat_q <= ST_OK;
      out_stat_q <= ST_OK;
    end else begin
      state_q    <= state_d;
      wr_vld_q   <= wr_vld_d;
      out_vld_q  <= out_vld_d;
      res_mem_q  <= res_mem_d;
      res_stat_q <= res_stat_d;
      out_stat_q <= out_stat_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEPS: steps_q <= cfg_data_i[3:0];
          REG_TERMS: terms_q <= cfg_data_i[2:0];
          default:   tw_q[cfg_idx_i - REG_TW_A] <= cfg_data_i;
        endcase
        // any register write drops the history
        cnt_q    <= '0;
        newest_q <= '0;
        filled_q <= 1'b0;
      end else begin
        cnt_q    <= cnt_d;
        newest_q <= newest_d;
        filled_q <= filled_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cp_slot_q <= cp_slot_d;
    cp_j_q    <= cp_j_d;
    cp_all_q  <= cp_all_d;
    wr_addr_q <= wr_addr_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    ebase_q   <= ebase_d;
    age_q     <= age_d;
    term_q    <= term_d;
    raddr_q   <= raddr_d;
    out_val_q <= out_val_d;
  end

  // Staging memory: write on append, read by the copy loop
  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      stg_mem[cnt_q[EW-1:0]] <= in_i.element_value;
    end
    stg_rdata_q <= stg_mem[cp_j_q];
  end

  // Frame ring memory
  always_ff @(posedge clk_i) begin
    if (wr_vld_q) begin
      frame_mem[wr_addr_q] <= stg_rdata_q;
    end
    frame_rdata_q <= frame_mem[raddr_q];
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= MAX_FRAME_WIDTH + 1)
    else $error("staged count beyond saturation");

  a_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stat_q != ST_OK |-> out_val_q == 32'd0)
    else $error("nonzero value with error status");

  a_wr_from_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_vld_q |-> $past(state_q == S_COPY))
    else $error("ring write outside the copy loop");

  a_copy_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COPY && !cfg_we_i |-> filled_q)
    else $error("copy while history empty");

endmodule

`default_nettype wire
